@@ design/msas_pkg.sv @@
// Shared types, widths and codes of the multiport SRAM access scoreboard.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package msas_pkg;

  localparam int LINE_COUNT_DEF  = 1024;
  localparam int NUM_PORTS_DEF   = 2;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TYPE_W = 2;
  localparam int ADDR_W = 16;
  localparam int LB_W   = 11;
  localparam int AC_W   = 7;
  localparam int KIND_W = 3;
  localparam int PORT_W = 3;
  localparam int LI_W   = ADDR_W + 1;
  localparam int CIDX_W = 1;

  localparam logic [TYPE_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NONE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_RD_DONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_DONE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QFULL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_LINE_BYTES    = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_ACCESS_CYCLES = 1'b1;

  localparam logic [1:0] RES_SRC_NONE = 2'd0;
  localparam logic [1:0] RES_SRC_IN   = 2'd1;
  localparam logic [1:0] RES_SRC_CUR  = 2'd2;

  typedef struct packed {
    logic              is_read;
    logic              partial;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic              wpart;
  } res_t;

  typedef struct packed {
    logic              load_in;
    logic              q_push;
    logic              q_pop;
    logic              cur_port;
    logic              cur_queue;
    logic              div_start;
    logic              div_size;
    logic              save_a;
    logic              save_n;
    logic              range_init;
    logic              line_inc;
    logic              vm_wr;
    logic              vm_wval;
    logic              vm_rd;
    logic              clr_step;
    logic              port_tick;
    logic              port_finish;
    logic              port_issue;
    logic              p_clr;
    logic              p_inc;
    logic              res_clr;
    logic              res_push;
    logic [1:0]        res_src;
    logic [KIND_W-1:0] res_kind;
    logic              drain;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] in_type;
    logic              q_full;
    logic              q_empty;
    logic              p_end;
    logic              busy;
    logic              finish;
    logic              cur_read;
    logic              lb_zero;
    logic              div_done;
    logic              bad;
    logic              line_more;
    logic              line_ok;
    logic              res_more;
    logic              out_free;
    logic              clr_done;
  } sts_t;

endpackage

`default_nettype wire

@@ design/msas_req_if.sv @@
// Request channel of the scoreboard: valid/ready and one request item.
// Depends on msas_pkg.
`default_nettype none

interface msas_req_if import msas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] size;
  logic              partial;

  modport source(output valid, req_type, addr, size, partial, input ready);
  modport sink(input valid, req_type, addr, size, partial, output ready);
endinterface

`default_nettype wire

@@ design/msas_res_if.sv @@
// Result channel of the scoreboard: valid/ready and one result item.
// Depends on msas_pkg.
`default_nettype none

interface msas_res_if import msas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PORT_W-1:0] port;
  logic [ADDR_W-1:0] done_addr;
  logic [ADDR_W-1:0] done_size;
  logic              was_partial;
  logic              working;
  logic              last;

  modport source(output valid, kind, port, done_addr, done_size, was_partial, working, last,
                 input ready);
  modport sink(input valid, kind, port, done_addr, done_size, was_partial, working, last,
               output ready);
endinterface

`default_nettype wire

@@ design/msas_cfg_if.sv @@
// Configuration write channel of the scoreboard: valid/ready, index and data.
// Depends on msas_pkg.
`default_nettype none

interface msas_cfg_if import msas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [LB_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/msas_div.sv @@
// Restoring divider, one quotient bit per cycle, for address and size by line size.
// Depends on msas_pkg.
`default_nettype none

module msas_div import msas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [LB_W-1:0]   divisor,
  output logic [ADDR_W-1:0] quot,
  output logic [LB_W-1:0]   rem,
  output logic              done
);

  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [LB_W:0]    trial;
  logic             fits;

  assign trial = {rem, quot[ADDR_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(ADDR_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (cnt != '0) begin
      if (fits) begin
        rem  <= LB_W'(trial - {1'b0, divisor});
        quot <= {quot[ADDR_W-2:0], 1'b1};
      end else begin
        rem  <= trial[LB_W-1:0];
        quot <= {quot[ADDR_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ design/msas_ctrl.sv @@
// Sequencer of the scoreboard: walks ports, queue offers and line ranges.
// Depends on msas_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module msas_ctrl import msas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_STAT  = 5'd3;
  localparam logic [4:0] S_DRAIN = 5'd4;
  localparam logic [4:0] S_ADV   = 5'd5;
  localparam logic [4:0] S_FIN   = 5'd6;
  localparam logic [4:0] S_FDA   = 5'd7;
  localparam logic [4:0] S_FDS   = 5'd8;
  localparam logic [4:0] S_FRNG  = 5'd9;
  localparam logic [4:0] S_MARK  = 5'd10;
  localparam logic [4:0] S_OFFER = 5'd11;
  localparam logic [4:0] S_QRD   = 5'd12;
  localparam logic [4:0] S_CHK   = 5'd13;
  localparam logic [4:0] S_CDA   = 5'd14;
  localparam logic [4:0] S_CDS   = 5'd15;
  localparam logic [4:0] S_CV    = 5'd16;
  localparam logic [4:0] S_SCAN  = 5'd17;
  localparam logic [4:0] S_SCHK  = 5'd18;
  localparam logic [4:0] S_CLR   = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.res_clr = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.in_type)
          REQ_READ, REQ_WRITE: begin
            if (sts.q_full) begin
              cmd.res_push = 1'b1;
              cmd.res_src  = RES_SRC_IN;
              cmd.res_kind = KIND_QFULL;
            end else begin
              cmd.q_push = 1'b1;
            end
            state_next = S_STAT;
          end
          REQ_TICK: begin
            cmd.p_clr  = 1'b1;
            state_next = S_ADV;
          end
          default: state_next = S_STAT;
        endcase
      end
      S_STAT: begin
        cmd.res_push = 1'b1;
        cmd.res_src  = RES_SRC_NONE;
        cmd.res_kind = KIND_STATUS;
        state_next   = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.res_more) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.drain = 1'b1;
        end
      end
      S_ADV: begin
        priority if (sts.p_end) begin
          cmd.p_clr  = 1'b1;
          state_next = S_OFFER;
        end else if (!sts.busy) begin
          cmd.p_inc = 1'b1;
        end else if (!sts.finish) begin
          cmd.port_tick = 1'b1;
          cmd.p_inc     = 1'b1;
        end else begin
          cmd.port_tick = 1'b1;
          cmd.cur_port  = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.cur_read || sts.lb_zero) begin
          cmd.res_push    = 1'b1;
          cmd.res_src     = RES_SRC_CUR;
          cmd.res_kind    = sts.cur_read ? KIND_RD_DONE : KIND_WR_DONE;
          cmd.port_finish = 1'b1;
          cmd.p_inc       = 1'b1;
          state_next      = S_ADV;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_FDA;
        end
      end
      S_FDA: begin
        if (sts.div_done) begin
          cmd.save_a    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_size  = 1'b1;
          state_next    = S_FDS;
        end
      end
      S_FDS: begin
        if (sts.div_done) begin
          cmd.save_n = 1'b1;
          state_next = S_FRNG;
        end
      end
      S_FRNG: begin
        cmd.range_init = 1'b1;
        state_next     = S_MARK;
      end
      S_MARK: begin
        if (sts.line_more) begin
          cmd.vm_wr    = 1'b1;
          cmd.vm_wval  = 1'b1;
          cmd.line_inc = 1'b1;
        end else begin
          cmd.res_push    = 1'b1;
          cmd.res_src     = RES_SRC_CUR;
          cmd.res_kind    = KIND_WR_DONE;
          cmd.port_finish = 1'b1;
          cmd.p_inc       = 1'b1;
          state_next      = S_ADV;
        end
      end
      S_OFFER: begin
        priority if (sts.p_end || sts.q_empty) begin
          state_next = S_STAT;
        end else if (sts.busy) begin
          cmd.p_inc = 1'b1;
        end else begin
          cmd.q_pop  = 1'b1;
          state_next = S_QRD;
        end
      end
      S_QRD: begin
        cmd.cur_queue = 1'b1;
        state_next    = S_CHK;
      end
      S_CHK: begin
        if (sts.lb_zero) begin
          cmd.res_push = 1'b1;
          cmd.res_src  = RES_SRC_CUR;
          cmd.res_kind = KIND_REJECT;
          cmd.p_inc    = 1'b1;
          state_next   = S_OFFER;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_CDA;
        end
      end
      S_CDA: begin
        if (sts.div_done) begin
          cmd.save_a    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_size  = 1'b1;
          state_next    = S_CDS;
        end
      end
      S_CDS: begin
        if (sts.div_done) begin
          cmd.save_n = 1'b1;
          state_next = S_CV;
        end
      end
      S_CV: begin
        if (sts.bad) begin
          cmd.res_push = 1'b1;
          cmd.res_src  = RES_SRC_CUR;
          cmd.res_kind = KIND_REJECT;
          cmd.p_inc    = 1'b1;
          state_next   = S_OFFER;
        end else begin
          cmd.range_init = 1'b1;
          state_next     = sts.cur_read ? S_SCAN : S_CLR;
        end
      end
      S_SCAN: begin
        if (sts.line_more) begin
          cmd.vm_rd  = 1'b1;
          state_next = S_SCHK;
        end else begin
          cmd.port_issue = 1'b1;
          cmd.p_inc      = 1'b1;
          state_next     = S_OFFER;
        end
      end
      S_SCHK: begin
        if (!sts.line_ok) begin
          cmd.res_push = 1'b1;
          cmd.res_src  = RES_SRC_CUR;
          cmd.res_kind = KIND_REJECT;
          cmd.p_inc    = 1'b1;
          state_next   = S_OFFER;
        end else begin
          cmd.line_inc = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_CLR: begin
        if (sts.line_more) begin
          cmd.vm_wr    = 1'b1;
          cmd.line_inc = 1'b1;
        end else begin
          cmd.port_issue = 1'b1;
          cmd.p_inc      = 1'b1;
          state_next     = S_OFFER;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

@@ design/msas_dp.sv @@
// Datapath of the scoreboard: request queue, port slots, line-valid memory,
// divider, result buffer and output register. Depends on msas_pkg and msas_div.
`default_nettype none

module msas_dp import msas_pkg::*; #(
  parameter int LINE_COUNT  = LINE_COUNT_DEF,
  parameter int NUM_PORTS   = NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [TYPE_W-1:0] req_type,
  input  logic [ADDR_W-1:0] req_addr,
  input  logic [ADDR_W-1:0] req_size,
  input  logic              req_partial,
  msas_res_if.source        res,
  msas_cfg_if.sink          cfg,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int LAW  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PAW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int PCW  = $clog2(NUM_PORTS + 1);
  localparam int RB   = 2 * NUM_PORTS + 1;
  localparam int RBAW = $clog2(RB);
  localparam int RBCW = $clog2(RB + 1);

  localparam logic [LI_W-1:0] NL_V    = LI_W'(LINE_COUNT);
  localparam logic [AC_W-1:0] CNT_MAX = '1;

  // configuration
  logic [LB_W-1:0] line_bytes;
  logic [AC_W-1:0] access_cycles;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes    <= LB_W'(16);
      access_cycles <= AC_W'(1);
    end else if (cfg.valid) begin
      if (cfg.index == CFG_LINE_BYTES) begin
        line_bytes <= cfg.data;
      end else begin
        access_cycles <= cfg.data[AC_W-1:0];
      end
    end
  end

  // input item
  logic [TYPE_W-1:0] in_type;
  req_t              in_req;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_type <= req_type;
      in_req  <= '{is_read: (req_type == REQ_READ), partial: req_partial,
                   addr: req_addr, size: req_size};
    end
  end

  // request queue
  req_t             qmem [QUEUE_DEPTH];
  req_t             qrd;
  logic [QAW-1:0]   qhead;
  logic [QCW-1:0]   qcount;
  logic [QCW:0]     tail_sum;
  logic [QAW-1:0]   qtail;

  always_comb begin
    tail_sum = (QCW+1)'(qhead) + (QCW+1)'(qcount);
    if (tail_sum >= (QCW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QCW+1)'(QUEUE_DEPTH);
    end
    qtail = tail_sum[QAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.q_push) qmem[qtail] <= in_req;
    if (cmd.q_pop) qrd <= qmem[qhead];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qhead  <= '0;
      qcount <= '0;
    end else if (cmd.q_push) begin
      qcount <= qcount + 1'b1;
    end else if (cmd.q_pop) begin
      qcount <= qcount - 1'b1;
      qhead  <= (qhead == QAW'(QUEUE_DEPTH - 1)) ? '0 : qhead + 1'b1;
    end
  end

  // request under work
  req_t cur;
  req_t preq [NUM_PORTS];

  // port slots
  logic              busy [NUM_PORTS];
  logic [AC_W-1:0]   pcnt [NUM_PORTS];
  logic [PCW-1:0]    p;
  logic [PAW-1:0]    pi;
  logic [AC_W-1:0]   cnt_next;
  logic              any_busy;

  assign pi       = p[PAW-1:0];
  assign cnt_next = (pcnt[pi] == CNT_MAX) ? pcnt[pi] : pcnt[pi] + 1'b1;

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      any_busy = any_busy | busy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        busy[i] <= 1'b0;
        pcnt[i] <= '0;
      end
    end else begin
      if (cmd.p_clr) begin
        p <= '0;
      end else if (cmd.p_inc) begin
        p <= p + 1'b1;
      end
      if (cmd.port_tick) pcnt[pi] <= cnt_next;
      if (cmd.port_finish) busy[pi] <= 1'b0;
      if (cmd.port_issue) begin
        busy[pi] <= 1'b1;
        pcnt[pi] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.port_issue) preq[pi] <= cur;
    if (cmd.cur_port) begin
      cur <= preq[pi];
    end else if (cmd.cur_queue) begin
      cur <= qrd;
    end
  end

  // line index arithmetic
  logic [ADDR_W-1:0] quot;
  logic [LB_W-1:0]   rem;
  logic              div_done;
  logic [LI_W-1:0]   qa;
  logic [LI_W-1:0]   qn;
  logic              ra_nz;
  logic              rn_nz;
  logic [LI_W-1:0]   lsum;
  logic [LI_W-1:0]   li;
  logic [LI_W-1:0]   lend;

  msas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_size ? cur.size : cur.addr),
    .divisor  (line_bytes),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  assign lsum = qa + qn;

  always_ff @(posedge clk) begin
    if (cmd.save_a) begin
      qa    <= LI_W'(quot);
      ra_nz <= |rem;
    end
    if (cmd.save_n) begin
      qn    <= LI_W'(quot);
      rn_nz <= |rem;
    end
    if (cmd.range_init) begin
      li   <= (qa > NL_V) ? NL_V : qa;
      lend <= (lsum > NL_V) ? NL_V : lsum;
    end else if (cmd.line_inc) begin
      li <= li + 1'b1;
    end
  end

  // line-valid memory, swept to all ones after reset
  logic            vmem [LINE_COUNT];
  logic            vrd;
  logic [LAW-1:0]  clr;
  logic [LAW-1:0]  vaddr;

  assign vaddr = cmd.clr_step ? clr : li[LAW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr_step || cmd.vm_wr) vmem[vaddr] <= cmd.clr_step | cmd.vm_wval;
    if (cmd.vm_rd) vrd <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_step) begin
      clr <= clr + 1'b1;
    end
  end

  // result buffer
  res_t             rbuf [RB];
  logic [RBCW-1:0]  rcnt;
  logic [RBCW-1:0]  ridx;
  res_t             new_res;

  always_comb begin
    unique case (cmd.res_src)
      RES_SRC_IN: new_res = '{kind: cmd.res_kind, port: '0, addr: in_req.addr,
                              size: in_req.size, wpart: !in_req.is_read && in_req.partial};
      RES_SRC_CUR: new_res = '{kind: cmd.res_kind, port: PORT_W'(p), addr: cur.addr,
                               size: cur.size, wpart: !cur.is_read && cur.partial};
      default: new_res = '{kind: cmd.res_kind, port: '0, addr: '0, size: '0, wpart: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_push) rbuf[rcnt[RBAW-1:0]] <= new_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
      ridx <= '0;
    end else if (cmd.res_clr) begin
      rcnt <= '0;
      ridx <= '0;
    end else begin
      if (cmd.res_push) rcnt <= rcnt + 1'b1;
      if (cmd.drain) ridx <= ridx + 1'b1;
    end
  end

  // output register
  logic ovalid;
  res_t opay;
  logic olast;
  logic owork;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.drain) begin
      ovalid <= 1'b1;
    end else if (res.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      opay  <= rbuf[ridx[RBAW-1:0]];
      olast <= (ridx == rcnt - 1'b1);
      owork <= any_busy || (qcount != '0);
    end
  end

  assign res.valid       = ovalid;
  assign res.kind        = opay.kind;
  assign res.port        = opay.port;
  assign res.done_addr   = opay.addr;
  assign res.done_size   = opay.size;
  assign res.was_partial = opay.wpart;
  assign res.working     = owork;
  assign res.last        = olast;

  // status to the sequencer
  assign sts.in_type   = in_type;
  assign sts.q_full    = (qcount == QCW'(QUEUE_DEPTH));
  assign sts.q_empty   = (qcount == '0);
  assign sts.p_end     = (p == PCW'(NUM_PORTS));
  assign sts.busy      = busy[pi];
  assign sts.finish    = (cnt_next >= access_cycles);
  assign sts.cur_read  = cur.is_read;
  assign sts.lb_zero   = (line_bytes == '0);
  assign sts.div_done  = div_done;
  assign sts.bad       = ra_nz || rn_nz || (qa >= NL_V) || (lsum > NL_V);
  assign sts.line_more = (li < lend);
  assign sts.line_ok   = vrd;
  assign sts.res_more  = (ridx < rcnt);
  assign sts.out_free  = !ovalid || res.ready;
  assign sts.clr_done  = (clr == LAW'(LINE_COUNT - 1));

endmodule

`default_nettype wire

@@ design/multiport_sram_access_scoreboard_unit.sv @@
// Top level of the multiport SRAM access scoreboard: sequencer plus datapath.
// Depends on msas_pkg, the channel interfaces, msas_ctrl and msas_dp.
//
// Channels: req carries pushes (read/write) and ticks; res returns the results of
// each request, ending with one status result marked last; cfg writes line_bytes
// (index 0) and access_cycles (index 1) and is always ready.
// One request is worked at a time. A tick walks the ports one per cycle, pausing
// at each port that finishes; a finishing write takes two divisions by line_bytes
// in the shared restoring divider and then marks its lines one by one. Each queued
// request offered with a nonzero line_bytes takes two divisions; if it fits, a write
// clears its lines one by one and a read checks each line through a registered
// memory read. After each request the results are drained from a small buffer,
// one per cycle while the receiver takes them; working is sampled at that point.
// After reset the line-valid memory is swept to all ones, with req.ready low.
// When the receiver stalls, the output register holds and the drain waits;
// req.ready rises again once the sequencer finds the buffer empty and returns
// to idle.
`default_nettype none

module multiport_sram_access_scoreboard_unit import msas_pkg::*; #(
  parameter int LINE_COUNT  = LINE_COUNT_DEF,
  parameter int NUM_PORTS   = NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  msas_req_if.sink   req,
  msas_res_if.source res,
  msas_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req.ready = in_ready;

  msas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msas_dp #(
    .LINE_COUNT  (LINE_COUNT),
    .NUM_PORTS   (NUM_PORTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req.req_type),
    .req_addr    (req.addr),
    .req_size    (req.size),
    .req_partial (req.partial),
    .res         (res),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

@@ design/msas_checker.sv @@
// Port-level checks of the scoreboard and their bind to the top level.
// Depends on msas_pkg and multiport_sram_access_scoreboard_unit.
`default_nettype none

module msas_checker import msas_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [KIND_W-1:0] res_kind,
  input logic [PORT_W-1:0] res_port,
  input logic [ADDR_W-1:0] res_done_addr,
  input logic [ADDR_W-1:0] res_done_size,
  input logic              res_last
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !(res_valid && !res_last))
    else $error("request taken before earlier results were delivered");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_last == (res_kind == KIND_STATUS)))
    else $error("status result and last flag disagree");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_STATUS |->
      res_port == '0 && res_done_addr == '0 && res_done_size == '0)
    else $error("status result carries request fields");

endmodule

bind multiport_sram_access_scoreboard_unit msas_checker u_msas_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_kind      (res.kind),
  .res_port      (res.port),
  .res_done_addr (res.done_addr),
  .res_done_size (res.done_size),
  .res_last      (res.last)
);

`default_nettype wire

@@ dv/multiport_sram_access_scoreboard_unit_tb.sv @@
// Self-checking testbench of the multiport SRAM access scoreboard: directed table, then random
// pushes and ticks, each result checked against a built-in scoreboard model.
// Depends on msas_pkg, the three channel interfaces and the top level.
`default_nettype none

module multiport_sram_access_scoreboard_unit_tb;
  import msas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLINES = LINE_COUNT_DEF;
  localparam int NPORTS = NUM_PORTS_DEF;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic              wpart;
    logic              working;
    logic              last;
  } outcome_t;

  typedef struct {
    logic [TYPE_W-1:0] rtype;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic              partial;
    logic              has_exp;
    outcome_t          exp_first;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  msas_req_if req ();
  msas_res_if res ();
  msas_cfg_if cfg ();

  multiport_sram_access_scoreboard_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source), .cfg(cfg.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scoreboard model state
  int unsigned line_bytes_m;
  int unsigned access_cycles_m;
  req_t        pend_q[$];
  logic        pbusy[NPORTS];
  int unsigned pcount[NPORTS];
  req_t        preq[NPORTS];
  logic        lvalid[NLINES];
  logic        lpartial[NLINES];

  outcome_t expected_q[$];
  int       mismatches = 0;
  int       cycles = 0;
  logic     quiet = 1'b0;
  logic     hold_res = 1'b0;

  function automatic outcome_t mk(logic [KIND_W-1:0] k, int p, req_t r, logic has_r);
    outcome_t o;
    o = '0;
    o.kind = k;
    o.port = PORT_W'(p);
    if (has_r) begin
      o.addr = r.addr;
      o.size = r.size;
      o.wpart = !r.is_read && r.partial;
    end
    return o;
  endfunction

  function automatic logic req_fits(req_t r);
    int unsigned a, n;
    if (line_bytes_m == 0) return 1'b0;
    if (r.addr % line_bytes_m != 0 || r.size % line_bytes_m != 0) return 1'b0;
    a = r.addr / line_bytes_m;
    n = r.size / line_bytes_m;
    if (a >= NLINES || a + n > NLINES) return 1'b0;
    if (r.is_read)
      for (int unsigned i = a; i < a + n; i++)
        if (!lvalid[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic line_span(req_t r, output int unsigned a, output int unsigned e);
    a = r.addr / line_bytes_m;
    e = a + r.size / line_bytes_m;
    if (a > NLINES) a = NLINES;
    if (e > NLINES) e = NLINES;
  endtask

  task automatic predict_access(logic [TYPE_W-1:0] t, req_t r);
    outcome_t outs[$];
    outcome_t o;
    int unsigned a, e;
    logic wk;
    req_t q;
    if (t == REQ_READ || t == REQ_WRITE) begin
      if (pend_q.size() >= QDEPTH) outs.push_back(mk(KIND_QFULL, 0, r, 1'b1));
      else pend_q.push_back(r);
    end else if (t == REQ_TICK) begin
      for (int p = 0; p < NPORTS; p++) begin
        if (!pbusy[p]) continue;
        if (pcount[p] < 127) pcount[p]++;
        if (pcount[p] >= access_cycles_m) begin
          if (!preq[p].is_read && line_bytes_m != 0) begin
            line_span(preq[p], a, e);
            for (int unsigned i = a; i < e; i++) begin
              lvalid[i] = 1'b1;
              lpartial[i] = preq[p].partial;
            end
          end
          outs.push_back(mk(preq[p].is_read ? KIND_RD_DONE : KIND_WR_DONE, p, preq[p], 1'b1));
          pbusy[p] = 1'b0;
        end
      end
      for (int p = 0; p < NPORTS && pend_q.size() != 0; p++) begin
        if (pbusy[p]) continue;
        q = pend_q.pop_front();
        if (!req_fits(q)) begin
          outs.push_back(mk(KIND_REJECT, p, q, 1'b1));
          continue;
        end
        if (!q.is_read) begin
          line_span(q, a, e);
          for (int unsigned i = a; i < e; i++) lvalid[i] = 1'b0;
        end
        pbusy[p] = 1'b1;
        pcount[p] = 0;
        preq[p] = q;
      end
    end
    outs.push_back(mk(KIND_STATUS, 0, r, 1'b0));
    wk = pend_q.size() != 0;
    for (int p = 0; p < NPORTS; p++) wk |= pbusy[p];
    foreach (outs[i]) begin
      o = outs[i];
      o.working = wk;
      o.last = (i == outs.size() - 1);
      expected_q.push_back(o);
    end
  endtask

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 11)) @(posedge clk);
  endtask

  task automatic send_request(logic [TYPE_W-1:0] t, logic [ADDR_W-1:0] ad,
                              logic [ADDR_W-1:0] sz, logic pt);
    req_t r;
    idle_burst();
    r.is_read = (t == REQ_READ);
    r.partial = pt;
    r.addr = ad;
    r.size = sz;
    req.valid <= 1'b1;
    req.req_type <= t;
    req.addr <= ad;
    req.size <= sz;
    req.partial <= pt;
    do @(posedge clk); while (!req.ready);
    predict_access(t, r);
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4000) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CIDX_W-1:0] idx, int unsigned val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= LB_W'(val);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_LINE_BYTES) line_bytes_m = val;
    else access_cycles_m = val;
    @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = {res.kind, res.port, res.done_addr, res.done_size, res.was_partial,
             res.working, res.last};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d port %0d addr %h size %h part %b wk %b last %b,"
                     , want.kind, want.port, want.addr, want.size, want.wpart, want.working,
                     want.last, " got kind %0d port %0d addr %h size %h part %b wk %b last %b",
                     got.kind, got.port, got.addr, got.size, got.wpart, got.working, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else if (hold_res) res.ready <= 1'b0;
    else if (!quiet && $urandom_range(0, 15) == 0) res.ready <= 1'b0;
    else res.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!quiet && res.ready && $urandom_range(0, 15) == 0) begin
      hold_res <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
      hold_res <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multiport_sram_access_scoreboard_unit_tb failed");
      $finish;
    end
  end

  function automatic row_t row(logic [TYPE_W-1:0] t, int unsigned ad, int unsigned sz, logic pt);
    row_t rw;
    rw.rtype = t;
    rw.addr = ADDR_W'(ad);
    rw.size = ADDR_W'(sz);
    rw.partial = pt;
    rw.has_exp = 1'b0;
    rw.exp_first = '0;
    return rw;
  endfunction

  task automatic random_phase(int n, logic well_formed);
    int unsigned lb, lines, a, k;
    logic [TYPE_W-1:0] t;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 4) t = REQ_TICK;
      else if (k < 6) t = REQ_READ;
      else if (k < 9) t = REQ_WRITE;
      else t = REQ_NONE;
      lb = (line_bytes_m == 0) ? 1 : line_bytes_m;
      if (well_formed && $urandom_range(0, 7) != 0) begin
        lines = (NLINES * lb > 65535) ? 65535 / lb : NLINES;
        a = $urandom_range(0, lines - 1);
        k = $urandom_range(0, 3) == 0 ? $urandom_range(0, lines - a)
                                      : $urandom_range(0, (lines - a) < 4 ? lines - a : 4);
        send_request(t, ADDR_W'(a * lb), ADDR_W'(k * lb), 1'($urandom_range(0, 1)));
      end else begin
        send_request(t, ADDR_W'($urandom_range(0, 65535)), ADDR_W'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    row_t dir[$];
    row_t rw;
    outcome_t o;
    req.valid = 1'b0;
    req.req_type = REQ_TICK;
    req.addr = '0;
    req.size = '0;
    req.partial = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_LINE_BYTES;
    cfg.data = '0;
    line_bytes_m = 16;
    access_cycles_m = 1;
    for (int i = 0; i < NLINES; i++) begin
      lvalid[i] = 1'b1;
      lpartial[i] = 1'b1;
    end
    for (int p = 0; p < NPORTS; p++) begin
      pbusy[p] = 1'b0;
      pcount[p] = 0;
      preq[p] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // tick after reset: idle status only
    rw = row(REQ_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
    rw.has_exp = 1'b1;
    rw.exp_first = {KIND_STATUS, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1};
    dir.push_back(rw);
    rw = row(REQ_NONE, 16'hFFFF, 16'hFFFF, 1'b1);
    rw.has_exp = 1'b1;
    rw.exp_first = {KIND_STATUS, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1};
    dir.push_back(rw);
    dir.push_back(row(REQ_WRITE, 0, 64, 1'b1));
    dir.push_back(row(REQ_READ, 0, 64, 1'b0));
    dir.push_back(row(REQ_TICK, 0, 0, 1'b0));
    dir.push_back(row(REQ_TICK, 0, 0, 1'b0));
    dir.push_back(row(REQ_READ, 0, 64, 1'b0));
    dir.push_back(row(REQ_READ, 3, 16, 1'b0));
    dir.push_back(row(REQ_WRITE, 16368, 32, 1'b0));
    dir.push_back(row(REQ_WRITE, 16384, 0, 1'b0));
    dir.push_back(row(REQ_READ, 16, 0, 1'b0));
    dir.push_back(row(REQ_WRITE, 16368, 16, 1'b0));
    dir.push_back(row(REQ_READ, 65535, 65535, 1'b1));
    for (int i = 0; i < 4; i++) dir.push_back(row(REQ_TICK, 0, 0, 1'b0));
    for (int i = 0; i < QDEPTH; i++) dir.push_back(row(REQ_WRITE, i * 16, 16, i[0]));
    rw = row(REQ_READ, 16'hABC0, 16'h0010, 1'b1);
    rw.has_exp = 1'b1;
    rw.exp_first = {KIND_QFULL, 3'd0, 16'hABC0, 16'h0010, 1'b0, 1'b1, 1'b0};
    dir.push_back(rw);
    foreach (dir[i]) begin
      send_request(dir[i].rtype, dir[i].addr, dir[i].size, dir[i].partial);
      if (dir[i].has_exp) begin
        o = expected_q[expected_q.size() - 1];
        for (int j = expected_q.size() - 1; j >= 0 && !(j < expected_q.size() - 1
             && expected_q[j].last); j--) o = expected_q[j];
        if (o !== dir[i].exp_first) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %h, predicted %h", i, dir[i].exp_first, o);
        end
      end
    end
    for (int i = 0; i < 20; i++) send_request(REQ_TICK, 0, 0, 1'b0);
    wait_drained();

    random_phase(50, 1'b1);
    for (int i = 0; i < 20; i++) send_request(REQ_TICK, 0, 0, 1'b0);
    wait_drained();
    write_cfg(CFG_LINE_BYTES, 1024);
    write_cfg(CFG_ACCESS_CYCLES, 64);
    random_phase(60, 1'b1);
    wait_drained();
    write_cfg(CFG_LINE_BYTES, 1);
    write_cfg(CFG_ACCESS_CYCLES, 0);
    random_phase(50, 1'b1);
    wait_drained();
    write_cfg(CFG_LINE_BYTES, 0);
    random_phase(20, 1'b0);
    wait_drained();
    write_cfg(CFG_LINE_BYTES, 2047);
    write_cfg(CFG_ACCESS_CYCLES, 127);
    random_phase(20, 1'b1);
    for (int i = 0; i < 8; i++) send_request(REQ_TICK, 0, 0, 1'b0);
    wait_drained();
    write_cfg(CFG_LINE_BYTES, 4);
    write_cfg(CFG_ACCESS_CYCLES, 3);
    random_phase(80, 1'b1);
    quiet = 1'b1;
    random_phase(40, 1'b1);
    for (int i = 0; i < 20; i++) send_request(REQ_TICK, 0, 0, 1'b0);
    wait_drained();

    if (mismatches == 0 && expected_q.size() == 0)
      $display("multiport_sram_access_scoreboard_unit_tb passed");
    else
      $display("multiport_sram_access_scoreboard_unit_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/msas_pkg.sv
design/msas_req_if.sv
design/msas_res_if.sv
design/msas_cfg_if.sv
design/msas_div.sv
design/msas_ctrl.sv
design/msas_dp.sv
design/multiport_sram_access_scoreboard_unit.sv
design/msas_checker.sv
dv/multiport_sram_access_scoreboard_unit_tb.sv
